@@ rtl/pvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_pkg: shared types and codes of the PCM voice mixer
// Beat structs, item kinds, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package pvm_pkg;

    localparam int VoiceSlotsDefault  = 8;
    localparam int StoreWordsDefault  = 4096;
    localparam int MaxChannelsDefault = 8;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_PLAY = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;
    localparam logic [1:0] KIND_MIX  = 2'd3;

    localparam logic [1:0] RES_STATUS = 2'd0;
    localparam logic [1:0] RES_SAMPLE = 2'd1;
    localparam logic [1:0] RES_FINISH = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_LOAD  = 3'd1;
    localparam logic [2:0] ST_BAD_VOL   = 3'd2;
    localparam logic [2:0] ST_BUSY      = 3'd3;
    localparam logic [2:0] ST_LIMIT     = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    localparam logic [0:0] CFG_VOICE_LIMIT  = 1'b0;
    localparam logic [0:0] CFG_OUT_CHANNELS = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        address;
        logic signed [15:0] sample_value;
        logic [2:0]         slot;
        logic [12:0]        asset_frames;
        logic [3:0]         asset_chans;
        logic [12:0]        volume;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [2:0]         status;
        logic [2:0]         channel;
        logic signed [15:0] mixed_sample;
        logic [2:0]         finished_slot;
        logic               finish_reason;
        logic               voice_contributed;
        logic               last;
    } t_out_item;

endpackage
`default_nettype wire

@@ rtl/pcm_voice_mixer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_voice_mixer: multi-voice PCM sample mixer
// Sample store plus voice slot table; load, play, stop and mix-frame items.
// ----------------------------------------------------------------------------
// Flow: load, play and stop are taken into the item register and answered from
//   the dispatch state into the output register; a stop's finished event
//   follows from the wait state. Mix: per output channel one store read per
//   slot, then the multiply pipe drains and the channel beat is sent; then
//   positions advance slot by slot and the slots are scanned for finished events.
// One item is worked on at a time; a beat waiting in the output register
//   holds the state machine wherever it must load the next beat.
// Reset clears voice valid bits and the active count and sets the configuration
//   to its defaults; store and slot fields stay undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module pcm_voice_mixer
    import pvm_pkg::*;
#(
    parameter int VOICE_SLOTS  = VoiceSlotsDefault,
    parameter int STORE_WORDS  = StoreWordsDefault,
    parameter int MAX_CHANNELS = MaxChannelsDefault
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_index,
    input  wire logic [3:0] i_cfg_data
);
    localparam int AW     = $clog2(STORE_WORDS);
    localparam int SU     = (VOICE_SLOTS < 8) ? VOICE_SLOTS : 8;
    localparam int CHCAP  = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
    localparam int SW     = (SU > 1) ? $clog2(SU) : 1;
    localparam logic [16:0] STORE_LIM = 17'(STORE_WORDS);

    typedef enum logic [2:0] {
        S_IDLE, S_ADDR, S_MAC, S_EMIT, S_ADV, S_DONE, S_WAIT
    } t_state;

    t_state r_state;
    t_in_item r_item;
    logic [3:0] r_limit, r_outch;
    logic [SU-1:0] r_active, r_done;
    logic [3:0] r_count;
    logic [11:0] r_base [SU];
    logic [12:0] r_len  [SU];
    logic [3:0]  r_cnt  [SU];
    logic [12:0] r_pos  [SU];
    logic [12:0] r_gain [SU];
    logic [2:0] r_ch;
    logic [SW-1:0] r_v;
    logic r_rd_pend;
    logic [SW-1:0] r_rd_v;
    logic signed [35:0] r_acc;
    logic signed [29:0] r_prod;
    logic r_prod_ok;
    logic r_any;
    logic [2:0] r_fin_idx;
    logic r_out_valid;
    t_out_item r_out;

    // Effective channel count of a mix.
    logic [3:0] nch;
    assign nch = (r_outch < 4'(CHCAP)) ? r_outch : 4'(CHCAP);

    // Store address of the current slot/channel.
    logic [3:0] src;
    logic [16:0] idx;
    logic [3:0] cm1;
    assign cm1 = r_cnt[r_v] - 4'd1;
    assign src = ({1'b0, r_ch} < cm1) ? {1'b0, r_ch} : cm1;
    assign idx = 17'(r_base[r_v]) + 17'(r_pos[r_v] * r_cnt[r_v]) + 17'(src);

    logic v_live;
    assign v_live = r_active[r_v] && (r_pos[r_v] < r_len[r_v]) && (r_cnt[r_v] != 4'd0);

    // Slots that play this frame, and slots that reach their end with it.
    logic [SU-1:0] live_vec, done_vec;
    always_comb begin
        for (int k = 0; k < SU; k++) begin
            live_vec[k] = r_active[k] && (r_pos[k] < r_len[k]) && (r_cnt[k] != 4'd0);
            done_vec[k] = r_active[k] && (!live_vec[k] || (r_pos[k] + 13'd1 >= r_len[k]));
        end
    end

    logic st_we;
    logic [AW-1:0] st_addr;
    logic signed [15:0] st_rdata;
    assign st_we   = (r_state == S_ADDR) && (r_item.kind == KIND_LOAD);
    assign st_addr = st_we ? AW'(r_item.address) : AW'(idx);

    pvm_store #(.STORE_WORDS(STORE_WORDS)) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_addr (st_addr),
        .i_wdata(r_item.sample_value),
        .o_rdata(st_rdata)
    );

    // Play checks, first match wins.
    logic [16:0] end_addr;
    logic [2:0] play_st;
    assign end_addr = 17'(r_item.address) + 17'(r_item.asset_frames * r_item.asset_chans);
    always_comb begin
        if (r_item.asset_frames == 13'd0 || r_item.asset_chans == 4'd0 ||
            r_item.asset_chans > 4'(MAX_CHANNELS > 15 ? 15 : MAX_CHANNELS) ||
            end_addr > STORE_LIM) begin
            play_st = ST_NOT_LOAD;
        end else if (32'(r_item.slot) >= SU) begin
            play_st = ST_NOT_FOUND;
        end else if (r_item.volume > 13'd4096) begin
            play_st = ST_BAD_VOL;
        end else if (r_active[SW'(r_item.slot)]) begin
            play_st = ST_BUSY;
        end else if (r_count >= r_limit) begin
            play_st = ST_LIMIT;
        end else begin
            play_st = ST_OK;
        end
    end

    // Round and saturate the accumulator to Q1.15.
    logic signed [35:0] rnd;
    logic signed [23:0] q;
    logic signed [15:0] sat;
    assign rnd = r_acc + 36'sd2048;
    assign q   = 24'(rnd >>> 12);
    assign sat = (q > 24'sd32767) ? 16'sh7fff : (q < -24'sd32768) ? 16'sh8000 : q[15:0];

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    logic stop_ok;
    assign stop_ok = (32'(r_item.slot) < SU) && r_active[SW'(r_item.slot)];

    logic [3:0] done_tail;
    always_comb begin
        done_tail = 4'd0;
        for (int k = 0; k < SU; k++) begin
            if (r_done[k] && k > int'(r_fin_idx)) done_tail = done_tail + 4'd1;
        end
    end

    // Channel beat is ready once the multiply pipe has drained and the output is free.
    logic emit_go;
    assign emit_go = !r_rd_pend && !r_prod_ok && out_free;

    // Next output beat, and whether it is loaded this cycle.
    logic out_load;
    t_out_item n_out;
    always_comb begin
        out_load = 1'b0;
        n_out    = '0;
        case (r_state)
            S_ADDR: begin
                if (out_free) begin
                    n_out.last = 1'b1;
                    case (r_item.kind)
                        KIND_LOAD: begin
                            out_load = 1'b1;
                        end
                        KIND_PLAY: begin
                            out_load            = 1'b1;
                            n_out.status        = play_st;
                            n_out.finished_slot = r_item.slot;
                        end
                        KIND_STOP: begin
                            out_load            = 1'b1;
                            n_out.finished_slot = r_item.slot;
                            if (stop_ok) n_out.last = 1'b0;
                            else n_out.status = ST_NOT_FOUND;
                        end
                        default: out_load = 1'b0;
                    endcase
                end
            end
            S_WAIT: begin
                // Second beat of a stop: finished event, reason stopped.
                if (out_free) begin
                    out_load            = 1'b1;
                    n_out.result_kind   = RES_FINISH;
                    n_out.finished_slot = r_item.slot;
                    n_out.last          = 1'b1;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    out_load                = 1'b1;
                    n_out.result_kind       = RES_SAMPLE;
                    n_out.channel           = r_ch;
                    n_out.mixed_sample      = sat;
                    n_out.voice_contributed = r_any;
                    n_out.last = ({1'b0, r_ch} == nch - 4'd1) && (r_done == '0);
                end
            end
            S_DONE: begin
                if (r_done[SW'(r_fin_idx)] && out_free) begin
                    out_load            = 1'b1;
                    n_out.result_kind   = RES_FINISH;
                    n_out.finished_slot = r_fin_idx;
                    n_out.finish_reason = 1'b1;
                    n_out.last          = (done_tail == 4'd0);
                end
            end
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= 4'd8;
            r_outch     <= 4'd2;
            r_active    <= '0;
            r_done      <= '0;
            r_count     <= 4'd0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_prod_ok   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_VOICE_LIMIT) r_limit <= i_cfg_data;
                else r_outch <= i_cfg_data;
            end
            // Load a new beat or drop the one just taken.
            if (out_load) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    // Dispatch on kind; load writes the store in this cycle.
                    if (out_free) begin
                        case (r_item.kind)
                            KIND_LOAD: begin
                                r_state <= S_IDLE;
                            end
                            KIND_PLAY: begin
                                if (play_st == ST_OK) begin
                                    r_active[SW'(r_item.slot)] <= 1'b1;
                                    r_base[SW'(r_item.slot)]   <= r_item.address;
                                    r_len[SW'(r_item.slot)]    <= r_item.asset_frames;
                                    r_cnt[SW'(r_item.slot)]    <= r_item.asset_chans;
                                    r_pos[SW'(r_item.slot)]    <= 13'd0;
                                    r_gain[SW'(r_item.slot)]   <= r_item.volume;
                                    r_count                    <= r_count + 4'd1;
                                end
                                r_state <= S_IDLE;
                            end
                            KIND_STOP: begin
                                if (stop_ok) begin
                                    r_active[SW'(r_item.slot)] <= 1'b0;
                                    if (r_count != 4'd0) r_count <= r_count - 4'd1;
                                    r_state <= S_WAIT;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            default: begin
                                if (nch == 4'd0) begin
                                    r_state <= S_IDLE;
                                end else begin
                                    r_ch      <= 3'd0;
                                    r_v       <= '0;
                                    r_acc     <= '0;
                                    r_any     <= 1'b0;
                                    r_done    <= done_vec;
                                    r_rd_pend <= 1'b0;
                                    r_prod_ok <= 1'b0;
                                    r_state   <= S_MAC;
                                end
                            end
                        endcase
                    end
                end
                S_WAIT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                S_MAC: begin
                    // Issue one read per slot, multiply next cycle, add after.
                    r_rd_pend <= v_live;
                    r_rd_v    <= r_v;
                    if (v_live) r_any <= 1'b1;
                    r_prod_ok <= r_rd_pend;
                    r_prod    <= st_rdata * $signed({1'b0, r_gain[r_rd_v]});
                    if (r_prod_ok) r_acc <= r_acc + 36'(r_prod);
                    if (32'(r_v) == SU - 1) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_v <= r_v + SW'(1);
                    end
                end
                S_EMIT: begin
                    // Drain the multiply pipe, then send the channel beat.
                    r_rd_pend <= 1'b0;
                    r_prod_ok <= r_rd_pend;
                    r_prod    <= st_rdata * $signed({1'b0, r_gain[r_rd_v]});
                    if (r_prod_ok) r_acc <= r_acc + 36'(r_prod);
                    if (emit_go) begin
                        r_acc <= '0;
                        r_v   <= '0;
                        if ({1'b0, r_ch} == nch - 4'd1) begin
                            r_state <= S_ADV;
                        end else begin
                            r_ch    <= r_ch + 3'd1;
                            r_state <= S_MAC;
                        end
                    end
                end
                S_ADV: begin
                    // Advance positions, one slot a cycle.
                    if (v_live) r_pos[r_v] <= r_pos[r_v] + 13'd1;
                    if (32'(r_v) == SU - 1) begin
                        r_fin_idx <= 3'd0;
                        r_state   <= (r_done == '0) ? S_IDLE : S_DONE;
                    end else begin
                        r_v <= r_v + SW'(1);
                    end
                end
                S_DONE: begin
                    // Emit finished events in slot order; free each slot.
                    if (r_done[SW'(r_fin_idx)]) begin
                        if (out_free) begin
                            r_active[SW'(r_fin_idx)] <= 1'b0;
                            r_count   <= r_count - 4'd1;
                            r_fin_idx <= r_fin_idx + 3'd1;
                            if (done_tail == 4'd0) r_state <= S_IDLE;
                        end
                    end else begin
                        r_fin_idx <= r_fin_idx + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Completions are known at dispatch, so the final sample beat carries
    // last when no voice finishes.
    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= 4'(SU);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("active count overflow");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rd_pend) else $error("read pending while idle");

    a_load_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> (r_state == S_ADDR)) else $error("store written outside dispatch");
endmodule
`default_nettype wire

@@ rtl/pvm_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_store: sample store
// Single-port synchronous memory of Q1.15 words with a registered read.
// ----------------------------------------------------------------------------
module pvm_store
    import pvm_pkg::*;
#(
    parameter int STORE_WORDS = StoreWordsDefault,
    localparam int AW = $clog2(STORE_WORDS)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_addr,
    input  wire logic signed [15:0] i_wdata,
    output logic signed [15:0]      o_rdata
);
    logic signed [15:0] r_mem [STORE_WORDS];
    logic signed [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for pcm_voice_mixer
// Drives load, play, stop and mix beats through the valid/ready input while a
// scoreboard mirrors the sample store and voice table, predicts each status,
// mixed sample and finished event, and checks every output beat in order.
// ----------------------------------------------------------------------------
module tb;
    import pvm_pkg::*;

    localparam int CycleLimit   = 1000000;
    localparam int SettleCycles = 150;

    // Mirror of the mixer: sample store, voice table and the queue of beats
    // still owed by the block.
    class mix_scoreboard;
        t_out_item          owed_q[$];
        logic signed [15:0] store [4096];
        bit                 active [8];
        logic [11:0]        base [8];
        logic [12:0]        length [8];
        logic [3:0]         chans [8];
        logic [12:0]        pos [8];
        logic [12:0]        gain [8];
        int unsigned        active_cnt;
        logic [3:0]         voice_limit;
        logic [3:0]         out_channels;
        int                 errors;
        int                 checked;

        function new();
            active_cnt   = 0;
            voice_limit  = 4'd8;
            out_channels = 4'd2;
            errors       = 0;
            checked      = 0;
            foreach (active[v]) active[v] = 1'b0;
        endfunction

        function void set_config(logic [0:0] idx, logic [3:0] val);
            if (idx == CFG_VOICE_LIMIT) voice_limit = val;
            else out_channels = val;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void owe(logic [1:0] rk, logic [2:0] st, logic [2:0] ch,
                          logic signed [15:0] smp, logic [2:0] sl,
                          logic reason, logic contrib);
            t_out_item b;
            b.result_kind       = rk;
            b.status            = st;
            b.channel           = ch;
            b.mixed_sample      = smp;
            b.finished_slot     = sl;
            b.finish_reason     = reason;
            b.voice_contributed = contrib;
            b.last              = 1'b0;
            owed_q.insert(owed_q.size(), b);
        endfunction

        function logic [2:0] play_status(t_in_item it);
            int span;
            span = int'(it.asset_frames) * int'(it.asset_chans);
            if (it.asset_frames == 0 || it.asset_chans == 0 || it.asset_chans > 8)
                return ST_NOT_LOAD;
            if (int'(it.address) + span > 4096) return ST_NOT_LOAD;
            if (it.volume > 13'd4096) return ST_BAD_VOL;
            if (active[it.slot]) return ST_BUSY;
            if (active_cnt >= voice_limit) return ST_LIMIT;
            return ST_OK;
        endfunction

        // Work out the beats an accepted input owes.
        function void note_input(t_in_item it);
            int         first;
            logic [2:0] st;
            t_out_item  tail;
            int         nch, src, idx;
            longint     acc [8];
            bit         done [8];
            bit         any;
            longint     q;

            first = owed_q.size();
            case (it.kind)
                KIND_LOAD: begin
                    store[it.address] = it.sample_value;
                    owe(RES_STATUS, ST_OK, 3'd0, 16'sd0, 3'd0, 1'b0, 1'b0);
                end
                KIND_PLAY: begin
                    st = play_status(it);
                    if (st == ST_OK) begin
                        active[it.slot] = 1'b1;
                        base[it.slot]   = it.address;
                        length[it.slot] = it.asset_frames;
                        chans[it.slot]  = it.asset_chans;
                        pos[it.slot]    = '0;
                        gain[it.slot]   = it.volume;
                        active_cnt++;
                    end
                    owe(RES_STATUS, st, 3'd0, 16'sd0, it.slot, 1'b0, 1'b0);
                end
                KIND_STOP: begin
                    if (!active[it.slot]) begin
                        owe(RES_STATUS, ST_NOT_FOUND, 3'd0, 16'sd0, it.slot, 1'b0, 1'b0);
                    end else begin
                        active[it.slot] = 1'b0;
                        if (active_cnt > 0) active_cnt--;
                        owe(RES_STATUS, ST_OK, 3'd0, 16'sd0, it.slot, 1'b0, 1'b0);
                        owe(RES_FINISH, ST_OK, 3'd0, 16'sd0, it.slot, 1'b0, 1'b0);
                    end
                end
                default: begin
                    nch = (out_channels < 8) ? int'(out_channels) : 8;
                    any = 1'b0;
                    foreach (acc[c]) acc[c] = 0;
                    foreach (done[v]) done[v] = 1'b0;
                    for (int v = 0; v < 8; v++) begin
                        if (!active[v]) continue;
                        if (nch == 0) continue;
                        if (pos[v] < length[v] && chans[v] != 0) begin
                            any = 1'b1;
                            for (int c = 0; c < nch; c++) begin
                                src = (c < int'(chans[v]) - 1) ? c : int'(chans[v]) - 1;
                                idx = (int'(base[v]) + int'(pos[v]) * int'(chans[v]) + src)
                                      % 4096;
                                acc[c] += longint'(store[idx]) * longint'(gain[v]);
                            end
                            pos[v] = pos[v] + 13'd1;
                        end
                        if (pos[v] >= length[v]) done[v] = 1'b1;
                    end
                    for (int c = 0; c < nch; c++) begin
                        q = (acc[c] + 2048) >>> 12;
                        if (q > 32767) q = 32767;
                        if (q < -32768) q = -32768;
                        owe(RES_SAMPLE, ST_OK, 3'(c), 16'(q), 3'd0, 1'b0, any);
                    end
                    for (int v = 0; v < 8; v++) begin
                        if (!done[v]) continue;
                        active[v] = 1'b0;
                        if (active_cnt > 0) active_cnt--;
                        owe(RES_FINISH, ST_OK, 3'd0, 16'sd0, 3'(v), 1'b1, 1'b0);
                    end
                end
            endcase
            if (owed_q.size() > first) begin
                tail      = owed_q[owed_q.size() - 1];
                tail.last = 1'b1;
                owed_q[owed_q.size() - 1] = tail;
            end
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        task check_field(string name, int got, int want);
            if (got != want)
                report($sformatf("beat %0d %s got %0d want %0d", checked, name, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (owed_q.size() == 0) begin
                report($sformatf("output beat %h with nothing owed", got));
                return;
            end
            want = owed_q.pop_front();
            check_field("result_kind", got.result_kind, want.result_kind);
            check_field("status", got.status, want.status);
            check_field("channel", got.channel, want.channel);
            check_field("mixed_sample", got.mixed_sample, want.mixed_sample);
            check_field("finished_slot", got.finished_slot, want.finished_slot);
            check_field("finish_reason", got.finish_reason, want.finish_reason);
            check_field("voice_contributed", got.voice_contributed, want.voice_contributed);
            check_field("last", got.last, want.last);
            checked++;
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   in_beat = '0;
    logic       o_out_valid;
    logic       out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [0:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;

    mix_scoreboard sb;
    bit  word_loaded [4096];
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    int  cycles = 0;
    int  beats_sent = 0;
    int  settings_run = 0;

    pcm_voice_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Hard stop if the block wedges.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: drop ready for a long hold-off when asked, else stall at random.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ready = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Check every output beat the moment it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) sb.check_result(o_out_data);
    end

    // Offer one input beat; called and returns at a falling edge.
    task automatic send_item(t_in_item it);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_beat  = it;
        in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [3:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_config(idx, val);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Hold until every owed beat has come, then let the block go quiet.
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_in_item mk(logic [1:0] k, logic [11:0] a, logic signed [15:0] s,
                                    logic [2:0] sl, logic [12:0] f, logic [3:0] c,
                                    logic [12:0] v);
        t_in_item it;
        it = '{kind: k, address: a, sample_value: s, slot: sl, asset_frames: f,
               asset_chans: c, volume: v};
        if (k == KIND_LOAD) word_loaded[a] = 1'b1;
        return it;
    endfunction

    // True when every word of the asset has been loaded.
    function automatic bit asset_loaded(int b, int span);
        for (int i = 0; i < span; i++) if (!word_loaded[b + i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_in_item random_item();
        logic [63:0] raw;
        t_in_item it;
        int       r, sc, fr, span, b;
        bit       found;
        raw = {$urandom, $urandom};
        it  = raw[62:0];
        r   = $urandom_range(0, 99);
        if (r < 30) begin
            // Keep most loads in a small window so plays find whole assets.
            it.kind    = KIND_LOAD;
            it.address = ($urandom_range(0, 99) < 80) ? 12'($urandom_range(0, 63))
                                                      : 12'($urandom);
            word_loaded[it.address] = 1'b1;
        end else if (r < 55) begin
            it.kind = KIND_PLAY;
            if ($urandom_range(0, 99) < 15) begin
                // Noise: any asset, but an over-range volume keeps it from starting.
                it.volume = 13'($urandom_range(4097, 8191));
            end else begin
                sc    = $urandom_range(1, 8);
                fr    = $urandom_range(1, 6);
                span  = sc * fr;
                found = 1'b0;
                for (int t = 0; t < 8 && !found; t++) begin
                    b = $urandom_range(0, 64 - span);
                    found = asset_loaded(b, span);
                end
                if (!found) begin
                    b  = 0;
                    sc = 1;
                    fr = 1;
                end
                it.address      = 12'(b);
                it.asset_chans  = 4'(sc);
                it.asset_frames = 13'(fr);
                it.volume       = ($urandom_range(0, 99) < 10)
                                  ? 13'($urandom_range(4097, 8191))
                                  : 13'($urandom_range(0, 4096));
            end
        end else if (r < 68) begin
            it.kind = KIND_STOP;
        end else begin
            it.kind = KIND_MIX;
        end
        return it;
    endfunction

    task automatic run_phase(logic [3:0] limit, logic [3:0] chans, int sp, int rp,
                             int count, int hold);
        write_reg(CFG_VOICE_LIMIT, limit);
        write_reg(CFG_OUT_CHANNELS, chans);
        send_idle_pct = sp;
        stall_pct     = rp;
        hold_left     = hold;
        settings_run++;
        repeat (count) send_item(random_item());
        drain();
    endtask

    initial begin
        sb = new();
        foreach (word_loaded[i]) word_loaded[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_reg(CFG_VOICE_LIMIT, 4'd8);
        write_reg(CFG_OUT_CHANNELS, 4'd2);

        // Directed: full-scale words, two unity voices to saturate both rails, busy,
        // unloaded and bad-volume play rejections, stop of a live and a dead slot, an empty mix.
        send_item(mk(KIND_LOAD, 12'd0, 16'sd32767, 3'd7, 13'h1fff, 4'hf, 13'h1fff));
        send_item(mk(KIND_LOAD, 12'd1, 16'sd32767, 3'd0, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_LOAD, 12'd2, -16'sd32768, 3'd0, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_LOAD, 12'd3, -16'sd32768, 3'd0, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_LOAD, 12'd4095, 16'sh5a5a, 3'd0, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_LOAD, 12'd4, 16'sd1, 3'd0, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_LOAD, 12'd5, -16'sd1, 3'd0, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_PLAY, 12'd0, 16'sd0, 3'd0, 13'd2, 4'd2, 13'd4096));
        send_item(mk(KIND_PLAY, 12'd0, 16'sd0, 3'd1, 13'd2, 4'd2, 13'd4096));
        send_item(mk(KIND_PLAY, 12'd0, 16'sd0, 3'd1, 13'd2, 4'd2, 13'd4096));
        send_item(mk(KIND_PLAY, 12'd0, 16'sd0, 3'd2, 13'd0, 4'd2, 13'd100));
        send_item(mk(KIND_PLAY, 12'd0, 16'sd0, 3'd2, 13'd1, 4'd0, 13'd100));
        send_item(mk(KIND_PLAY, 12'd0, 16'sd0, 3'd2, 13'd1, 4'd9, 13'd100));
        send_item(mk(KIND_PLAY, 12'd4095, 16'sd0, 3'd2, 13'd2, 4'd1, 13'd100));
        send_item(mk(KIND_PLAY, 12'd0, 16'sd0, 3'd2, 13'd4096, 4'd1, 13'd8191));
        send_item(mk(KIND_PLAY, 12'd4, 16'sd0, 3'd2, 13'd1, 4'd1, 13'd4097));
        send_item(mk(KIND_MIX, 12'd0, 16'sd0, 3'd0, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_MIX, 12'd0, 16'sd0, 3'd0, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_PLAY, 12'd4, 16'sd0, 3'd3, 13'd1, 4'd2, 13'd0));
        send_item(mk(KIND_STOP, 12'd0, 16'sd0, 3'd3, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_STOP, 12'd0, 16'sd0, 3'd3, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_STOP, 12'd0, 16'sd0, 3'd7, 13'd0, 4'd0, 13'd0));
        send_item(mk(KIND_MIX, 12'd0, 16'sd0, 3'd0, 13'd0, 4'd0, 13'd0));
        drain();

        // Random phases; the zero-channel one must produce no mix beats, and
        // the long receiver hold-off backs the block up into its input.
        run_phase(4'd8, 4'd8, 0, 0, 40, 0);
        run_phase(4'd3, 4'd1, 79, 0, 40, 0);
        run_phase(4'd0, 4'd0, 0, 79, 12, 0);
        run_phase(4'd5, 4'd4, 0, 79, 40, 0);
        run_phase(4'd1, 4'd3, 0, 0, 40, 600);
        run_phase(4'd8, 4'd8, 38, 38, 45, 0);
        run_phase(4'd2, 4'd5, 0, 0, 20, 0);

        if (sb.pending() > 0) sb.report($sformatf("%0d beats never came", sb.pending()));
        $display("run covered %0d input beats and %0d output beats over %0d register settings",
                 beats_sent, sb.checked, settings_run + 1);
        $display("mismatches counted: %0d, cycles used: %0d", sb.errors, cycles);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
